// ----- rtl/core/dq_pkg.sv -----
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned WordW        = 32;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned CountOutW    = 11;

  typedef enum logic [CmdW-1:0] {
    OpPushFront = 3'd0,
    OpPushBack  = 3'd1,
    OpPopFront  = 3'd2,
    OpPopBack   = 3'd3,
    OpLook      = 3'd4,
    OpSpare5    = 3'd5,
    OpSpare6    = 3'd6,
    OpSpare7    = 3'd7
  } dq_op_e;

  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic signed [WordW-1:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] popped_value;
    logic                    popped_valid;
    logic signed [WordW-1:0] front_value;
    logic signed [WordW-1:0] back_value;
    logic [CountOutW-1:0]    entry_count;
    logic                    is_empty_flag;
    logic                    push_dropped;
  } dq_out_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic fill;
  } dq_ctl_t;

  typedef struct packed {
    logic rd_needed;
  } dq_sts_t;

endpackage

// ----- rtl/core/dq_ctrl.sv -----
// Transaction sequencer for the double-ended queue.
module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dq_pkg::dq_sts_t sts_i,
  output dq_pkg::dq_ctl_t ctl_o
);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StFill,
    StResp
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = sts_i.rd_needed ? StFill : StResp;
      end
      StFill: begin
        state_d = StResp;
      end
      StResp: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StResp);
  assign ctl_o.latch = in_valid_i && (state_q == StIdle);
  assign ctl_o.exec  = (state_q == StExec);
  assign ctl_o.fill  = (state_q == StFill);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides open together");

  a_fill_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill) |-> ($past(state_q) == StExec))
    else $error("fill entered without an execute step");

  a_latch_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.latch |=> ctl_o.exec)
    else $error("latched transaction not executed");

endmodule

// ----- rtl/core/dq_dpath.sv -----
// Ring store, pointers, word caches and result registers of the deque.
module dq_dpath #(
  parameter int unsigned DEPTH = dq_pkg::DepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dq_pkg::dq_ctl_t ctl_i,
  output dq_pkg::dq_sts_t sts_o,
  input  dq_pkg::dq_in_t  in_data_i,
  output dq_pkg::dq_out_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = dq_pkg::WordW;

  logic [WW-1:0] mem [DEPTH];

  logic [dq_pkg::CmdW-1:0] cmd_q, cmd_d;
  logic [WW-1:0]           value_q, value_d;
  logic [AW-1:0]           front_q, front_d, back_q, back_d;
  logic [CW-1:0]           count_q, count_d;
  logic [WW-1:0]           front_w_q, front_w_d, back_w_q, back_w_d;
  logic [WW-1:0]           popped_q, popped_d;
  logic                    pvalid_q, pvalid_d;
  logic                    dropped_q, dropped_d;
  logic                    rd_front_q, rd_front_d;
  logic [WW-1:0]           rd_data_q;

  logic          full, empty, is_pop;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign back_inc  = (back_q == AW'(DEPTH - 1)) ? '0 : back_q + AW'(1);
  assign back_dec  = (back_q == '0) ? AW'(DEPTH - 1) : back_q - AW'(1);

  assign is_pop          = (cmd_q == dq_pkg::OpPopFront) || (cmd_q == dq_pkg::OpPopBack);
  assign sts_o.rd_needed = is_pop && (count_q > CW'(1));

  always_comb begin
    cmd_d      = cmd_q;
    value_d    = value_q;
    front_d    = front_q;
    back_d     = back_q;
    count_d    = count_q;
    front_w_d  = front_w_q;
    back_w_d   = back_w_q;
    popped_d   = popped_q;
    pvalid_d   = pvalid_q;
    dropped_d  = dropped_q;
    rd_front_d = rd_front_q;
    wr_en      = 1'b0;
    wr_addr    = front_q;
    rd_en      = 1'b0;
    rd_addr    = front_q;

    if (ctl_i.latch) begin
      cmd_d   = in_data_i.cmd;
      value_d = in_data_i.push_value;
    end

    if (ctl_i.exec) begin
      popped_d  = '0;
      pvalid_d  = 1'b0;
      dropped_d = 1'b0;
      case (cmd_q)
        dq_pkg::OpPushFront: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            front_d   = front_dec;
            count_d   = count_q + CW'(1);
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            front_w_d = value_q;
            if (empty) begin
              back_w_d = value_q;
            end
          end
        end
        dq_pkg::OpPushBack: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            back_d   = back_inc;
            count_d  = count_q + CW'(1);
            wr_en    = 1'b1;
            wr_addr  = back_inc;
            back_w_d = value_q;
            if (empty) begin
              front_w_d = value_q;
            end
          end
        end
        dq_pkg::OpPopFront: begin
          if (!empty) begin
            popped_d   = front_w_q;
            pvalid_d   = 1'b1;
            front_d    = front_inc;
            count_d    = count_q - CW'(1);
            rd_en      = 1'b1;
            rd_addr    = front_inc;
            rd_front_d = 1'b1;
          end
        end
        dq_pkg::OpPopBack: begin
          if (!empty) begin
            popped_d   = back_w_q;
            pvalid_d   = 1'b1;
            back_d     = back_dec;
            count_d    = count_q - CW'(1);
            rd_en      = 1'b1;
            rd_addr    = back_dec;
            rd_front_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (ctl_i.fill) begin
      if (rd_front_q) begin
        front_w_d = rd_data_q;
      end else begin
        back_w_d = rd_data_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= AW'(DEPTH - 1);
      count_q <= '0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    value_q    <= value_d;
    front_w_q  <= front_w_d;
    back_w_q   <= back_w_d;
    popped_q   <= popped_d;
    pvalid_q   <= pvalid_d;
    dropped_q  <= dropped_d;
    rd_front_q <= rd_front_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_data_o.popped_value  = popped_q;
  assign out_data_o.popped_valid  = pvalid_q;
  assign out_data_o.front_value   = empty ? '0 : front_w_q;
  assign out_data_o.back_value    = empty ? '0 : back_w_q;
  assign out_data_o.entry_count   = dq_pkg::CountOutW'(count_q);
  assign out_data_o.is_empty_flag = empty;
  assign out_data_o.push_dropped  = dropped_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_back_tracks_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((int'(front_q) + int'(count_q) + int'(DEPTH) - 1 - int'(back_q)) == 0) ||
    ((int'(front_q) + int'(count_q) + int'(DEPTH) - 1 - int'(back_q)) == int'(DEPTH)) ||
    ((int'(front_q) + int'(count_q) + int'(DEPTH) - 1 - int'(back_q)) == 2 * int'(DEPTH)))
    else $error("back index out of step with front index and count");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.exec && !full &&
     ((cmd_q == dq_pkg::OpPushFront) || (cmd_q == dq_pkg::OpPushBack)))
    |=> (count_q == $past(count_q) + CW'(1)))
    else $error("accepted push did not grow the count");

endmodule

// ----- rtl/core/double_ended_queue.sv -----
// The result is presented after the execute state, or after the execute and fill states for
// a pop that leaves words, which refills its end word from the store's registered read data.
// A new transaction is accepted only in the idle state, once the previous result is taken;
// the ring store has a single read port.
// Reset clears the front index and count and sets the back index to the last entry; the ring
// store is not cleared and needs no clearing pass, since only written entries are ever used.
module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dq_pkg::dq_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dq_pkg::dq_out_t out_data_o
);

  dq_pkg::dq_ctl_t ctl;
  dq_pkg::dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  dq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
